FILE: rtl/scct_pkg.sv
`default_nettype none

package scct_pkg;

    // bytes per scratchpad frame, 2 to 16
    localparam int FRAME_BYTES = 9;

    localparam int COUNT_W = 4;

    // reflected form of x^8+x^5+x^4+1
    localparam logic [7:0] CRC_POLY = 8'h8C;

    localparam logic [7:0] CRC_INIT = 8'h00;

    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [7:0] crc_t;

    localparam count_t LAST_INDEX = COUNT_W'(FRAME_BYTES - 1);

    // one byte of the dallas/maxim crc, lsb first
    function automatic crc_t crc8_update(input crc_t crc, input logic [7:0] data);
        crc_t v;
        v = crc ^ data;
        for (int k = 0; k < 8; k++)
        begin
            if (v[0])
            begin
                v = (v >> 1) ^ CRC_POLY;
            end
            else
            begin
                v = v >> 1;
            end
        end
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/scratchpad_crc_temperature_check.sv
// scratchpad frame checker with dallas/maxim crc-8
//
// input channel: in_valid / in_ready carry one scratchpad byte (data_byte)
// per beat, in frame order. every FRAME_BYTES beats form one frame.
// output channel: out_valid / out_ready carry one beat per frame with
// temperature_raw (held raw temperature) and crc_ok.
// on the last byte of a frame the crc residue is checked; when it is zero
// the held temperature takes byte1*256+byte0, otherwise it keeps its value.
// the result beat shows up in the cycle after the last input beat.
// throughput: one input byte per cycle while in_ready is high; the crc update, byte capture and
// result build are a single combinational pass into the result register.
// stall: the result register doubles as the output buffer; inner bytes of
// a frame are still taken while a result waits, and only the last byte of
// the next frame is held off (in_ready low) until the waiting result is
// taken. in_ready also stays high in the cycle out_ready drains the slot.
// reset (rst_n low, asynchronous): byte counter and crc restart at frame
// start, held temperature goes to 0, no result is pending.
`default_nettype none

module scratchpad_crc_temperature_check
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  data_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [15:0]      temperature_raw,
    output logic             crc_ok
);

    scct_pkg::count_t byte_count_reg;
    scct_pkg::count_t byte_count_next;
    scct_pkg::crc_t   crc_reg;
    scct_pkg::crc_t   crc_next;
    scct_pkg::crc_t   crc_step;
    logic [7:0]       first_byte_reg;
    logic [7:0]       second_byte_reg;
    logic [7:0]       second_byte_cur;
    logic [15:0]      held_temperature_reg;
    logic [15:0]      held_temperature_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [15:0]      temperature_raw_reg;
    logic             crc_ok_reg;
    logic             in_fire;
    logic             out_fire;
    logic             last_byte;
    logic             frame_ok;
    logic             slot_free;

    // last byte when the count reaches the frame end (or beyond)
    assign last_byte = (byte_count_reg >= scct_pkg::LAST_INDEX);

    // output slot is free when empty or being drained this cycle
    assign slot_free = !out_valid_reg || out_ready;

    // inner bytes never need the output slot
    assign in_ready  = !last_byte || slot_free;
    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid_reg && out_ready;

    assign crc_step  = scct_pkg::crc8_update(crc_reg, data_byte);
    assign frame_ok  = (crc_step == scct_pkg::CRC_INIT);

    // in a two-byte frame the high byte arrives with the last beat
    assign second_byte_cur = (byte_count_reg == scct_pkg::count_t'(1)) ? data_byte
                                                                       : second_byte_reg;

    always_comb
    begin
        byte_count_next       = byte_count_reg;
        crc_next              = crc_reg;
        held_temperature_next = held_temperature_reg;
        out_valid_next        = out_valid_reg && !out_fire;
        if (in_fire)
        begin
            if (last_byte)
            begin
                // frame done: restart counter and crc, post one result
                byte_count_next = '0;
                crc_next        = scct_pkg::CRC_INIT;
                out_valid_next  = 1'b1;
                if (frame_ok)
                begin
                    held_temperature_next = {second_byte_cur, first_byte_reg};
                end
            end
            else
            begin
                byte_count_next = byte_count_reg + scct_pkg::count_t'(1);
                crc_next        = crc_step;
            end
        end
    end

    // control state and held temperature
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg       <= '0;
            crc_reg              <= scct_pkg::CRC_INIT;
            held_temperature_reg <= '0;
            out_valid_reg        <= 1'b0;
        end
        else
        begin
            byte_count_reg       <= byte_count_next;
            crc_reg              <= crc_next;
            held_temperature_reg <= held_temperature_next;
            out_valid_reg        <= out_valid_next;
        end
    end

    // payload capture, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            if (byte_count_reg == scct_pkg::count_t'(0))
            begin
                first_byte_reg <= data_byte;
            end
            if (byte_count_reg == scct_pkg::count_t'(1))
            begin
                second_byte_reg <= data_byte;
            end
            if (last_byte)
            begin
                temperature_raw_reg <= held_temperature_next;
                crc_ok_reg          <= frame_ok;
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign temperature_raw = temperature_raw_reg;
    assign crc_ok          = crc_ok_reg;

    // a pending result always mirrors the held temperature
    a_result_matches_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (temperature_raw_reg == held_temperature_reg))
        else $error("pending result differs from held temperature");

    // counter never runs past the frame end
    a_count_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        byte_count_reg <= scct_pkg::LAST_INDEX)
        else $error("byte counter beyond frame end");

    // frame end restarts counter and crc
    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && last_byte) |=>
            (byte_count_reg == '0) && (crc_reg == scct_pkg::CRC_INIT))
        else $error("frame end did not restart counter and crc");

    // an inner byte never posts a result
    a_inner_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && !last_byte && !out_valid_reg) |=> !out_valid_reg)
        else $error("result posted on an inner byte");

    // a failed crc leaves the held temperature alone
    a_bad_crc_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && last_byte && !frame_ok) |=>
            $stable(held_temperature_reg))
        else $error("held temperature changed on crc failure");

endmodule

`default_nettype wire

FILE: bench/scratchpad_crc_temperature_check_tb.sv
`timescale 1ns / 1ps

module scratchpad_crc_temperature_check_tb;

    // watchdog limit on cycles, far above what the slowest run needs
    localparam int CYCLE_LIMIT   = 400000;
    // about 1650 bytes in all, together with the directed frames
    localparam int RANDOM_FRAMES = 180;
    localparam int LAST_POS      = scct_pkg::FRAME_BYTES - 1;

    typedef logic [7:0] frame_t [scct_pkg::FRAME_BYTES];

    // one temperature reading as the block should report it
    typedef struct packed
    {
        logic [15:0] temperature;
        logic        ok;
    } reading_t;

    // receiver stall patterns
    typedef enum logic [1:0]
    {
        DRAIN_ALWAYS,
        DRAIN_COIN,
        DRAIN_SPARSE,
        DRAIN_PERIODIC
    } drain_mode_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_byte;
    logic        out_valid;
    logic        out_ready;
    logic [15:0] temperature_raw;
    logic        crc_ok;

    // lookup table of the dallas/maxim crc, filled at time zero
    scct_pkg::crc_t   crc_table [256];

    // expected state of the frame checker
    scct_pkg::count_t frame_pos;
    scct_pkg::crc_t   running_crc;
    logic [7:0]  low_byte;
    logic [7:0]  high_byte;
    logic [15:0] held_temp;
    reading_t    pending_readings [$];

    // sender burst control
    int          burst_left;

    // receiver stall control
    drain_mode_t drain_mode;
    int          drain_left;
    logic [3:0]  drain_tick;

    int          cycle_count;
    int          error_count;
    int          bytes_sent;
    int          frames_closed;
    int          readings_checked;
    int          readings_passed;

    scratchpad_crc_temperature_check dut
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .data_byte       (data_byte),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .temperature_raw (temperature_raw),
        .crc_ok          (crc_ok)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // one line per mismatch, counted for the final verdict
    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at %0t ns: %s got 0x%0h want 0x%0h", $time, what, got, want);
        error_count++;
    endtask

    // crc over the first count bytes of a frame
    function automatic scct_pkg::crc_t frame_crc(input frame_t f, input int count);
        scct_pkg::crc_t c;
        c = scct_pkg::CRC_INIT;
        for (int i = 0; i < count; i++)
        begin
            c = crc_table[c ^ f[i]];
        end
        return c;
    endfunction

    // advance the expected state by one accepted byte; the last byte of a
    // frame queues the reading the block should produce
    task automatic track_byte(input logic [7:0] b);
        reading_t r;
        running_crc = crc_table[running_crc ^ b];
        if (frame_pos == 0)
        begin
            low_byte = b;
        end
        else if (frame_pos == 1)
        begin
            high_byte = b;
        end
        if (frame_pos < scct_pkg::LAST_INDEX)
        begin
            frame_pos++;
        end
        else
        begin
            // zero residue means the frame is intact and the reading is taken
            r.ok = (running_crc == 8'h00);
            if (r.ok)
            begin
                held_temp = {high_byte, low_byte};
            end
            r.temperature = held_temp;
            pending_readings.push_back(r);
            frame_pos   = '0;
            running_crc = scct_pkg::CRC_INIT;
            frames_closed++;
        end
    endtask

    // entered and left at a falling edge; holds the beat until accepted
    task automatic send_byte(input logic [7:0] b);
        if (burst_left == 0)
        begin
            // gap between bursts, then a fresh burst length; now and then a
            // long burst gives a stretch with no idling at all
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 24);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        track_byte(b);
        bytes_sent++;
        burst_left--;
        @(negedge clk);
    endtask

    task automatic send_frame(input frame_t f);
        for (int i = 0; i < scct_pkg::FRAME_BYTES; i++)
        begin
            send_byte(f[i]);
        end
    endtask

    // a bad check byte right after reset must leave the held value at zero
    task automatic test_bad_crc_after_reset();
        frame_t f;
        for (int i = 0; i < LAST_POS; i++)
        begin
            f[i] = 8'h5A + 8'(i);
        end
        f[LAST_POS] = frame_crc(f, LAST_POS) ^ 8'h01;
        send_frame(f);
    endtask

    // all-ones data gives the top reading, all-zeros a valid zero reading
    task automatic test_extreme_frames();
        frame_t f;
        for (int i = 0; i < LAST_POS; i++)
        begin
            f[i] = 8'hFF;
        end
        f[LAST_POS] = frame_crc(f, LAST_POS);
        send_frame(f);
        for (int i = 0; i < scct_pkg::FRAME_BYTES; i++)
        begin
            f[i] = 8'h00;
        end
        send_frame(f);
    endtask

    // mostly intact frames with random content, the rest damaged or noise
    task automatic test_random_frames();
        frame_t f;
        int     kind;
        int     pos;
        for (int n = 0; n < RANDOM_FRAMES; n++)
        begin
            for (int i = 0; i < LAST_POS; i++)
            begin
                f[i] = 8'($urandom_range(0, 255));
            end
            // push the temperature bytes to their extremes now and then
            if ($urandom_range(0, 9) == 0)
            begin
                f[0] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                f[1] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            end
            f[LAST_POS] = frame_crc(f, LAST_POS);
            kind = $urandom_range(0, 19);
            if (kind >= 14 && kind <= 16)
            begin
                // wrong check byte
                f[LAST_POS] ^= 8'($urandom_range(1, 255));
            end
            else if (kind == 17 || kind == 18)
            begin
                // single flipped bit anywhere in the frame
                pos = $urandom_range(0, LAST_POS);
                f[pos][$urandom_range(0, 7)] ^= 1'b1;
            end
            else if (kind == 19)
            begin
                // plain noise, the check byte included
                for (int i = 0; i < scct_pkg::FRAME_BYTES; i++)
                begin
                    f[i] = 8'($urandom_range(0, 255));
                end
            end
            send_frame(f);
        end
    endtask

    // compare each result beat with the oldest pending reading
    always @(posedge clk)
    begin
        reading_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_readings.size() == 0)
            begin
                report_mismatch("unexpected result beat, temperature_raw", temperature_raw, 0);
            end
            else
            begin
                want = pending_readings.pop_front();
                if (temperature_raw !== want.temperature)
                begin
                    report_mismatch("temperature_raw", temperature_raw, want.temperature);
                end
                if (crc_ok !== want.ok)
                begin
                    report_mismatch("crc_ok", crc_ok, want.ok);
                end
                readings_checked++;
                if (want.ok)
                begin
                    readings_passed++;
                end
            end
        end
    end

    // receiver: switches between stall patterns at random intervals
    always @(negedge clk)
    begin
        if (drain_left == 0)
        begin
            drain_mode = drain_mode_t'($urandom_range(0, 3));
            drain_left = $urandom_range(20, 120);
        end
        drain_left--;
        drain_tick++;
        case (drain_mode)
            DRAIN_ALWAYS:   out_ready <= 1'b1;
            DRAIN_COIN:     out_ready <= 1'($urandom_range(0, 1));
            DRAIN_SPARSE:   out_ready <= ($urandom_range(0, 7) == 0);
            DRAIN_PERIODIC: out_ready <= (drain_tick[3:2] == 2'b11);
            default:        out_ready <= 1'b1;
        endcase
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d readings still pending",
                     cycle_count, pending_readings.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        // build the crc lookup table bit by bit from the reflected polynomial
        for (int i = 0; i < 256; i++)
        begin
            crc_table[i] = 8'(i);
            for (int k = 0; k < 8; k++)
            begin
                crc_table[i] = crc_table[i][0]
                             ? ((crc_table[i] >> 1) ^ scct_pkg::CRC_POLY)
                             : (crc_table[i] >> 1);
            end
        end

        rst_n            = 1'b0;
        in_valid         = 1'b0;
        data_byte        = 8'h00;
        out_ready        = 1'b0;
        frame_pos        = '0;
        running_crc      = scct_pkg::CRC_INIT;
        low_byte         = 8'h00;
        high_byte        = 8'h00;
        held_temp        = 16'h0000;
        burst_left       = 0;
        drain_mode       = DRAIN_ALWAYS;
        drain_left       = 0;
        drain_tick       = '0;
        cycle_count      = 0;
        error_count      = 0;
        bytes_sent       = 0;
        frames_closed    = 0;
        readings_checked = 0;
        readings_passed  = 0;

        // hold reset, then release it away from the rising edge
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_bad_crc_after_reset();
        test_extreme_frames();
        test_random_frames();

        in_valid <= 1'b0;

        // drain, then wait on a little to catch any stray result beat
        while (pending_readings.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);

        $display("sent %0d bytes in %0d frames; checked %0d readings, %0d with a clean crc",
                 bytes_sent, frames_closed, readings_checked, readings_passed);
        $display("sender bursts and receiver stall patterns were randomized throughout");
        if (error_count == 0 && pending_readings.size() == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("%0d mismatches, %0d readings never arrived",
                     error_count, pending_readings.size());
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

FILE: scratchpad_crc_temperature_check.f
rtl/scct_pkg.sv
rtl/scratchpad_crc_temperature_check.sv
bench/scratchpad_crc_temperature_check_tb.sv
